[src/rfb_pkg.sv]
// ----------------------------------------------------------------------------
// rfb_pkg
// Shared types and constants for the framebuffer rectangle decoder.
// ----------------------------------------------------------------------------
package rfb_pkg;

  localparam int TILE_SIZE   = 16;
  localparam int PIXEL_BYTES = 4;
  localparam int QUEUE_DEPTH = 4;

  // command codes
  localparam logic [2:0] CMD_FILL    = 3'd0;
  localparam logic [2:0] CMD_PIXEL   = 3'd1;
  localparam logic [2:0] CMD_COPY    = 3'd2;
  localparam logic [2:0] CMD_SIZEERR = 3'd3;
  localparam logic [2:0] CMD_UNKNOWN = 3'd4;

  // register indexes
  localparam logic [1:0] REG_CROP_X  = 2'd0;
  localparam logic [1:0] REG_CROP_Y  = 2'd1;
  localparam logic [1:0] REG_FRAME_W = 2'd2;
  localparam logic [1:0] REG_FRAME_H = 2'd3;

  // request handed from the front part to the back part
  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
  } byte_req_t;

  // configuration as seen by the back part
  typedef struct packed {
    logic [15:0] crop_x;
    logic [15:0] crop_y;
    logic [15:0] frame_w;
    logic [15:0] frame_h;
  } cfg_t;

endpackage

[src/rfb_queue.sv]
// ----------------------------------------------------------------------------
// rfb_queue
// Short request queue between the byte front end and the parser.
// ----------------------------------------------------------------------------
module rfb_queue
  import rfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  byte_req_t in_req,
  output logic      out_valid,
  input  logic      out_stall,
  output byte_req_t out_req
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  byte_req_t       mem [QUEUE_DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [AW:0]     count;
  logic            push;
  logic            pop;

  assign in_stall  = (count == (AW+1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_req   = mem[rptr];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_req;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(QUEUE_DEPTH)) else $error("queue overflow");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("count slip");
  a_empty_novalid: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !out_valid) else $error("valid while empty");

endmodule

[src/rfb_parser.sv]
// ----------------------------------------------------------------------------
// rfb_parser
// Back part: walks the rectangle header and payload one byte a cycle unless
// stalled, and produces commands into an output register.
// ----------------------------------------------------------------------------
module rfb_parser
  import rfb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  byte_req_t          in_req,
  output logic               valid,
  input  logic               stall,
  output logic [2:0]         command_kind,
  output logic signed [17:0] dest_x,
  output logic signed [17:0] dest_y,
  output logic [15:0]        fill_width,
  output logic [15:0]        fill_height,
  output logic [31:0]        pixel_color,
  output logic [15:0]        copy_src_x,
  output logic [15:0]        copy_src_y,
  output logic               rect_done
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_HDR, PH_PROD, PH_CHECK, PH_PIX, PH_COPY, PH_RHEAD, PH_RSUB,
    PH_XENC, PH_XBG, PH_XFG, PH_XCOUNT, PH_XSUB
  } phase_t;

  phase_t             phase;
  logic [3:0]         bidx;
  logic [31:0]        gather;
  logic signed [17:0] rleft, rtop;
  logic [15:0]        rwide, rtall;
  logic [31:0]        enc;
  logic [31:0]        subs;
  logic signed [17:0] tleft, ttop;
  logic [4:0]         tflags;
  logic [31:0]        bg, fg;
  logic [15:0]        pcol, prow;
  logic [63:0]        geom;
  // size check products, registered
  logic [31:0]        prod_wh;
  logic signed [35:0] prod_xy;
  logic [31:0]        prod_fr;

  logic               take;
  logic               out_busy;
  logic [7:0]         b;
  logic signed [18:0] rright, rbot;
  logic               tlast;
  logic [15:0]        tw, th;
  logic [31:0]        gsh;

  // no byte is taken while the size check is in progress
  assign out_busy = valid && stall;
  assign in_stall = out_busy || phase == PH_PROD || phase == PH_CHECK;
  assign take     = in_valid && !in_stall;
  assign b        = in_req.data;
  assign gsh      = {b, gather[31:8]};
  assign rright   = 19'(rleft) + 19'($signed({1'b0, rwide}));
  assign rbot     = 19'(rtop)  + 19'($signed({1'b0, rtall}));
  assign tlast    = (19'(tleft) + 19'sd16 >= rright) && (19'(ttop) + 19'sd16 >= rbot);

  // clipped tile size
  always_comb begin
    logic signed [18:0] rw, rh;
    rw = rright - 19'(tleft);
    rh = rbot - 19'(ttop);
    tw = (rw > 19'sd16) ? 16'd16 : rw[15:0];
    th = (rh > 19'sd16) ? 16'd16 : rh[15:0];
  end

  // parser state and output register
  always_ff @(posedge clk) begin
    logic [15:0]        pc_n, pr_n, rwv, rhv;
    logic signed [17:0] ox, oy;
    logic [31:0]        sn;
    logic               cl;
    logic [3:0]         n;
    logic [7:0]         xy, wh;
    logic [63:0]        gm;
    logic signed [18:0] tl_n, tt_n;
    logic               hex;
    logic signed [36:0] lhs;
    if (rst) begin
      phase <= PH_IDLE;
      bidx  <= '0;
      gather <= '0;
      valid <= 1'b0;
      rleft <= '0; rtop <= '0; rwide <= '0; rtall <= '0;
      enc <= '0; subs <= '0; tleft <= '0; ttop <= '0; tflags <= '0;
      bg <= '0; fg <= '0; pcol <= '0; prow <= '0; geom <= '0;
    end else begin
      if (valid && !stall) valid <= 1'b0;
      if (phase == PH_PROD) begin
        // products settle from the new header fields
        phase <= PH_CHECK;
      end else if (phase == PH_CHECK && !out_busy) begin
        // size check once the products are registered and the output is free
        lhs = 37'($signed({5'b0, prod_wh})) + 37'(prod_xy);
        phase <= PH_IDLE;
        if (lhs > 37'($signed({5'b0, prod_fr}))) begin
          valid <= 1'b1; command_kind <= CMD_SIZEERR;
          dest_x <= rleft; dest_y <= rtop; fill_width <= rwide; fill_height <= rtall;
          pixel_color <= '0; copy_src_x <= '0; copy_src_y <= '0; rect_done <= 1'b1;
        end else if (enc == 32'd0 || enc == 32'd5) begin
          if (rwide == '0 || rtall == '0) begin
            valid <= 1'b1; command_kind <= CMD_FILL;
            dest_x <= rleft; dest_y <= rtop; fill_width <= rwide; fill_height <= rtall;
            pixel_color <= '0; copy_src_x <= '0; copy_src_y <= '0; rect_done <= 1'b1;
          end else begin
            tleft <= rleft; ttop <= rtop;
            phase <= (enc == 32'd0) ? PH_PIX : PH_XENC;
          end
        end else if (enc == 32'd1) begin
          phase <= PH_COPY;
        end else if (enc == 32'd2 || enc == 32'd4) begin
          phase <= PH_RHEAD;
        end else begin
          valid <= 1'b1; command_kind <= CMD_UNKNOWN;
          dest_x <= rleft; dest_y <= rtop; fill_width <= rwide; fill_height <= rtall;
          pixel_color <= '0; copy_src_x <= '0; copy_src_y <= '0; rect_done <= 1'b1;
        end
      end else if (take) begin
        if (in_req.hdr || phase == PH_HDR) begin
          // header bytes
          if (in_req.hdr) begin
            bidx <= 4'd1;
            geom <= {geom[55:0], b};
            phase <= PH_HDR;
          end else begin
            if (bidx < 4'd8) geom <= {geom[55:0], b};
            else gather <= {gather[23:0], b};
            bidx <= bidx + 1'b1;
            if (bidx == 4'd11) begin
              rwide <= geom[31:16]; rtall <= geom[15:0];
              rleft <= 18'($signed({2'b0, geom[63:48]}) - $signed({2'b0, cfg.crop_x}));
              rtop  <= 18'($signed({2'b0, geom[47:32]}) - $signed({2'b0, cfg.crop_y}));
              enc <= {gather[23:0], b};
              bg <= '0; fg <= '0; bidx <= '0; pcol <= '0; prow <= '0; subs <= '0;
              phase <= PH_PROD;
            end
          end
        end else begin
          case (phase)
            PH_PIX: begin
              hex = (enc == 32'd5);
              ox  = hex ? tleft : rleft;
              oy  = hex ? ttop : rtop;
              rwv = hex ? tw : rwide;
              rhv = hex ? th : rtall;
              gather <= gsh;
              if (bidx < 4'(PIXEL_BYTES - 1)) begin
                bidx <= bidx + 1'b1;
              end else begin
                bidx <= '0;
                pc_n = pcol + 1'b1; pr_n = prow;
                if (pc_n >= rwv) begin pc_n = '0; pr_n = prow + 1'b1; end
                valid <= 1'b1; command_kind <= CMD_PIXEL;
                dest_x <= ox + 18'($signed({2'b0, pcol}));
                dest_y <= oy + 18'($signed({2'b0, prow}));
                fill_width <= 16'd1; fill_height <= 16'd1; pixel_color <= gsh;
                copy_src_x <= '0; copy_src_y <= '0;
                rect_done <= (pr_n >= rhv) && (!hex || tlast);
                pcol <= pc_n; prow <= pr_n;
                if (pr_n >= rhv) begin
                  prow <= '0;
                  if (hex) begin
                    tl_n = 19'(tleft) + 19'sd16;
                    tt_n = 19'(ttop);
                    if (tl_n >= rright) begin tl_n = 19'(rleft); tt_n = tt_n + 19'sd16; end
                    tleft <= 18'(tl_n); ttop <= 18'(tt_n);
                    phase <= (tt_n >= rbot) ? PH_IDLE : PH_XENC;
                  end else phase <= PH_IDLE;
                end
              end
            end
            PH_COPY: begin
              gather <= {gather[23:0], b};
              if (bidx < 4'd3) bidx <= bidx + 1'b1;
              else begin
                bidx <= '0; phase <= PH_IDLE;
                valid <= 1'b1; command_kind <= CMD_COPY;
                dest_x <= rleft; dest_y <= rtop; fill_width <= rwide; fill_height <= rtall;
                pixel_color <= '0;
                copy_src_x <= gather[23:8] - cfg.crop_x;
                copy_src_y <= {gather[7:0], b} - cfg.crop_y;
                rect_done <= 1'b1;
              end
            end
            PH_RHEAD: begin
              sn = subs;
              if (bidx < 4'd4) begin sn = {subs[23:0], b}; subs <= sn; end
              else gather <= gsh;
              if (bidx < 4'd7) bidx <= bidx + 1'b1;
              else begin
                bidx <= '0; bg <= gsh;
                phase <= (sn == '0) ? PH_IDLE : PH_RSUB;
                valid <= 1'b1; command_kind <= CMD_FILL;
                dest_x <= rleft; dest_y <= rtop; fill_width <= rwide; fill_height <= rtall;
                pixel_color <= gsh; copy_src_x <= '0; copy_src_y <= '0;
                rect_done <= (sn == '0);
              end
            end
            PH_RSUB: begin
              n = (enc == 32'd2) ? 4'd12 : 4'd8;
              gm = geom;
              if (bidx < 4'd4) gather <= gsh;
              else begin gm = {geom[55:0], b}; geom <= gm; end
              if (bidx < n - 1'b1) bidx <= bidx + 1'b1;
              else begin
                bidx <= '0;
                sn = subs - 1'b1; subs <= sn;
                if (sn == '0) phase <= PH_IDLE;
                valid <= 1'b1; command_kind <= CMD_FILL;
                if (enc == 32'd2) begin
                  dest_x <= rleft + 18'($signed({2'b0, gm[63:48]}));
                  dest_y <= rtop + 18'($signed({2'b0, gm[47:32]}));
                  fill_width <= gm[31:16]; fill_height <= gm[15:0];
                end else begin
                  dest_x <= rleft + 18'($signed({10'b0, gm[31:24]}));
                  dest_y <= rtop + 18'($signed({10'b0, gm[23:16]}));
                  fill_width <= {8'b0, gm[15:8]}; fill_height <= {8'b0, gm[7:0]};
                end
                pixel_color <= gather; copy_src_x <= '0; copy_src_y <= '0;
                rect_done <= (sn == '0);
              end
            end
            PH_XENC, PH_XBG, PH_XFG, PH_XCOUNT, PH_XSUB: begin
              // hextile: prefix and subrects; background fill on last prefix byte
              logic       fill, more, adv, pref;
              logic [31:0] bgv, fgv;
              logic [4:0]  fl;
              fill = 1'b0; more = 1'b0; adv = 1'b0; pref = 1'b0;
              bgv = bg; fgv = fg; fl = tflags;
              if (phase == PH_XENC) begin
                fl = b[4:0]; tflags <= fl; bidx <= '0;
                if (fl[0]) begin pcol <= '0; prow <= '0; phase <= PH_PIX; end
                else if (fl[1]) phase <= PH_XBG;
                else if (fl[2]) phase <= PH_XFG;
                else pref = 1'b1;
              end else if (phase == PH_XBG || phase == PH_XFG) begin
                gather <= gsh;
                if (bidx < 4'd3) bidx <= bidx + 1'b1;
                else begin
                  bidx <= '0;
                  if (phase == PH_XBG) begin
                    bgv = gsh; bg <= gsh;
                    if (fl[2]) phase <= PH_XFG; else pref = 1'b1;
                  end else begin
                    fgv = gsh; fg <= gsh; pref = 1'b1;
                  end
                end
              end else if (phase == PH_XCOUNT) begin
                subs <= {24'b0, b}; bidx <= '0;
                fill = 1'b1; more = (b != 8'd0);
                if (more) phase <= PH_XSUB; else adv = 1'b1;
              end
              if (pref) begin
                if (fl[3]) phase <= PH_XCOUNT;
                else begin fill = 1'b1; adv = 1'b1; end
              end
              if (phase == PH_XSUB) begin
                cl = fl[4];
                n = cl ? 4'd6 : 4'd2;
                gm = geom;
                if (bidx < n - 4'd2) gather <= gsh;
                else begin gm = {geom[55:0], b}; geom <= gm; end
                if (bidx < n - 1'b1) bidx <= bidx + 1'b1;
                else begin
                  bidx <= '0;
                  if (cl) begin fgv = gather; fg <= gather; end
                  xy = gm[15:8]; wh = gm[7:0];
                  sn = subs - 1'b1; subs <= sn;
                  valid <= 1'b1; command_kind <= CMD_FILL;
                  dest_x <= tleft + 18'($signed({14'b0, xy[7:4]}));
                  dest_y <= ttop + 18'($signed({14'b0, xy[3:0]}));
                  fill_width <= 16'd1 + {12'b0, wh[7:4]};
                  fill_height <= 16'd1 + {12'b0, wh[3:0]};
                  pixel_color <= fgv; copy_src_x <= '0; copy_src_y <= '0;
                  rect_done <= (sn == '0) && tlast;
                  adv = (sn == '0);
                end
              end
              if (fill) begin
                valid <= 1'b1; command_kind <= CMD_FILL;
                dest_x <= tleft; dest_y <= ttop; fill_width <= tw; fill_height <= th;
                pixel_color <= bgv; copy_src_x <= '0; copy_src_y <= '0;
                rect_done <= tlast && !more;
              end
              if (adv) begin
                bidx <= '0;
                tl_n = 19'(tleft) + 19'sd16;
                tt_n = 19'(ttop);
                if (tl_n >= rright) begin tl_n = 19'(rleft); tt_n = tt_n + 19'sd16; end
                tleft <= 18'(tl_n); ttop <= 18'(tt_n);
                phase <= (tt_n >= rbot) ? PH_IDLE : PH_XENC;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  // size check products
  always_ff @(posedge clk) begin
    prod_wh <= rwide * rtall;
    prod_xy <= rleft * rtop;
    prod_fr <= cfg.frame_w * cfg.frame_h;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (valid && stall) |=> valid && $stable(command_kind) && $stable(dest_x))
    else $error("result dropped under stall");
  a_no_take_stalled: assert property (@(posedge clk) disable iff (rst)
    (valid && stall) |-> in_stall) else $error("byte taken over pending result");
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> command_kind <= CMD_UNKNOWN) else $error("bad command");

endmodule

[src/remote_framebuffer_rect_decoder.sv]
// ----------------------------------------------------------------------------
// remote_framebuffer_rect_decoder
// Decodes framebuffer-update rectangles (raw, copy, RRE, CoRE, hextile)
// from a byte stream into fill, pixel, copy, size-error and unknown commands.
// ----------------------------------------------------------------------------
// channel   direction  handshake        payload
// stream    in         valid / stall    stream_byte, header_start
// command   out        valid / stall    command_kind .. rect_done
// config    in         APB              four 16-bit registers
//
// One byte a cycle is taken in steady state; the parser handles one byte per
// cycle unless the output stalls, and after each header awaits the size check
// (products registered, then compared). Results leave from one output register.
// Reset is synchronous and leaves the parser idle waiting for a header.
// Output stall holds the result register; the byte queue absorbs the rest.
// ----------------------------------------------------------------------------
module remote_framebuffer_rect_decoder
  import rfb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         stream_byte,
  input  logic               header_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         command_kind,
  output logic signed [17:0] dest_x,
  output logic signed [17:0] dest_y,
  output logic [15:0]        fill_width,
  output logic [15:0]        fill_height,
  output logic [31:0]        pixel_color,
  output logic [15:0]        copy_src_x,
  output logic [15:0]        copy_src_y,
  output logic               rect_done
);

  cfg_t      cfg;
  byte_req_t in_req, q_req;
  logic      q_valid, q_stall;
  logic [1:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[3:2];

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_CROP_X:  cfg.crop_x  <= pwdata[15:0];
        REG_CROP_Y:  cfg.crop_y  <= pwdata[15:0];
        REG_FRAME_W: cfg.frame_w <= pwdata[15:0];
        REG_FRAME_H: cfg.frame_h <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_CROP_X:  prdata = {16'b0, cfg.crop_x};
      REG_CROP_Y:  prdata = {16'b0, cfg.crop_y};
      REG_FRAME_W: prdata = {16'b0, cfg.frame_w};
      REG_FRAME_H: prdata = {16'b0, cfg.frame_h};
      default:     prdata = '0;
    endcase
  end

  assign in_req.data = stream_byte;
  assign in_req.hdr  = header_start;

  rfb_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(q_valid), .out_stall(q_stall), .out_req(q_req)
  );

  rfb_parser u_parser (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(q_valid), .in_stall(q_stall), .in_req(q_req),
    .valid(out_valid), .stall(out_stall),
    .command_kind(command_kind), .dest_x(dest_x), .dest_y(dest_y),
    .fill_width(fill_width), .fill_height(fill_height),
    .pixel_color(pixel_color), .copy_src_x(copy_src_x),
    .copy_src_y(copy_src_y), .rect_done(rect_done)
  );

endmodule

[tb/remote_framebuffer_rect_decoder_test.sv]
// ----------------------------------------------------------------------------
// remote_framebuffer_rect_decoder_test
// Drives framebuffer-update rectangles (raw, copy, RRE, CoRE, hextile and
// unknown encodings, truncated and noisy streams) into the decoder under
// random sender gaps and receiver stalls, and checks every command against a
// behavioural decoder kept alongside it, over several crop and frame settings.
// ----------------------------------------------------------------------------
module remote_framebuffer_rect_decoder_test;
  import rfb_pkg::*;

  localparam logic [31:0] ENC_RAW  = 32'd0;
  localparam logic [31:0] ENC_COPY = 32'd1;
  localparam logic [31:0] ENC_RRE  = 32'd2;
  localparam logic [31:0] ENC_CORE = 32'd4;
  localparam logic [31:0] ENC_HEX  = 32'd5;

  typedef enum int {
    P_IDLE, P_HDR, P_PIX, P_COPY, P_RHEAD, P_RSUB,
    P_XENC, P_XBG, P_XFG, P_XCOUNT, P_XSUB
  } parse_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [17:0] dx;
    logic [17:0] dy;
    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] color;
    logic [15:0] sx;
    logic [15:0] sy;
    logic        done;
  } cmd_t;

  typedef struct {
    logic [15:0] x, y, w, h;
    logic [31:0] enc;
    int          cut;
    int          noise;
    bit          typed;
    cmd_t        want;
  } rect_row_t;

  logic               clk = 0;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid, in_stall;
  logic [7:0]         stream_byte;
  logic               header_start;
  logic               out_valid, out_stall;
  logic [2:0]         command_kind;
  logic signed [17:0] dest_x, dest_y;
  logic [15:0]        fill_width, fill_height;
  logic [31:0]        pixel_color;
  logic [15:0]        copy_src_x, copy_src_y;
  logic               rect_done;

  remote_framebuffer_rect_decoder dut (.*);

  always #5 clk = ~clk;

  // decoder state mirrored for prediction
  logic [15:0] crop_x, crop_y, frame_w, frame_h;
  parse_e      phase;
  int          bidx;
  logic [31:0] gather, enc_type, subs_left, bg_col, fg_col;
  int          rl, rt, rw, rh, tl, tt, pcol, prow;
  logic [4:0]  tflags;
  logic [63:0] geom;
  bit          emitted;
  cmd_t        cmd_out;

  cmd_t        cmd_expq[$];
  logic [8:0]  pend[$];
  logic [7:0]  payload[$];
  int          cap;
  int          errs, nbytes;
  int          gap_pct, stall_pct, hold;
  bit          typed_on;
  cmd_t        typed_cmd;
  rect_row_t   dir_tab[15];

  function automatic cmd_t mk_cmd(logic [2:0] k, int dx, int dy, int w, int h,
                                  logic [31:0] col, logic [15:0] sx, logic [15:0] sy,
                                  bit d);
    cmd_t c;
    c.kind = k; c.dx = dx[17:0]; c.dy = dy[17:0]; c.w = w[15:0]; c.h = h[15:0];
    c.color = col; c.sx = sx; c.sy = sy; c.done = d;
    return c;
  endfunction

  function void emit_cmd(logic [2:0] k, int dx, int dy, int w, int h,
                         logic [31:0] col, logic [15:0] sx, logic [15:0] sy, bit d);
    cmd_out = mk_cmd(k, dx, dy, w, h, col, sx, sy, d);
    emitted = 1;
  endfunction

  function int tile_w();
    int r;
    r = rl + rw - tl;
    return r > TILE_SIZE ? TILE_SIZE : r;
  endfunction

  function int tile_h();
    int r;
    r = rt + rh - tt;
    return r > TILE_SIZE ? TILE_SIZE : r;
  endfunction

  function bit tile_last();
    return tl + TILE_SIZE >= rl + rw && tt + TILE_SIZE >= rt + rh;
  endfunction

  function void tile_next();
    bidx = 0;
    tl += TILE_SIZE;
    if (tl >= rl + rw) begin
      tl = rl;
      tt += TILE_SIZE;
      if (tt >= rt + rh) begin
        phase = P_IDLE;
        return;
      end
    end
    phase = P_XENC;
  endfunction

  function void tile_fill(bit more);
    emit_cmd(CMD_FILL, tl, tt, tile_w(), tile_h(), bg_col, 0, 0, tile_last() && !more);
    if (!more) tile_next();
  endfunction

  // stage 0 after subencoding, 1 after background, 2 after foreground
  function void prefix_next(int stage);
    bidx = 0;
    if (stage < 1 && tflags[1]) phase = P_XBG;
    else if (stage < 2 && tflags[2]) phase = P_XFG;
    else if (tflags[3]) phase = P_XCOUNT;
    else tile_fill(0);
  endfunction

  function void header_done();
    longint lhs, rhs;
    rw = geom[31:16];
    rh = geom[15:0];
    rl = int'(geom[63:48]) - int'(crop_x);
    rt = int'(geom[47:32]) - int'(crop_y);
    enc_type = gather;
    bg_col = 0; fg_col = 0; bidx = 0; pcol = 0; prow = 0; subs_left = 0;
    phase = P_IDLE;
    lhs = longint'(rw) * rh + longint'(rl) * rt;
    rhs = longint'(frame_w) * longint'(frame_h);
    if (lhs > rhs) begin
      emit_cmd(CMD_SIZEERR, rl, rt, rw, rh, 0, 0, 0, 1);
      return;
    end
    case (enc_type)
      ENC_RAW, ENC_HEX: begin
        if (rw == 0 || rh == 0) emit_cmd(CMD_FILL, rl, rt, rw, rh, 0, 0, 0, 1);
        else begin
          tl = rl;
          tt = rt;
          phase = enc_type == ENC_RAW ? P_PIX : P_XENC;
        end
      end
      ENC_COPY: phase = P_COPY;
      ENC_RRE, ENC_CORE: phase = P_RHEAD;
      default: emit_cmd(CMD_UNKNOWN, rl, rt, rw, rh, 0, 0, 0, 1);
    endcase
  endfunction

  function void pixel_in(logic [7:0] b);
    bit hx, rend, last;
    int ox, oy, w, h, px, py;
    hx = enc_type == ENC_HEX;
    ox = hx ? tl : rl;
    oy = hx ? tt : rt;
    w = hx ? tile_w() : rw;
    h = hx ? tile_h() : rh;
    gather = {b, gather[31:8]};
    if (bidx < PIXEL_BYTES - 1) begin
      bidx++;
      return;
    end
    bidx = 0;
    px = ox + pcol;
    py = oy + prow;
    pcol++;
    if (pcol >= w) begin
      pcol = 0;
      prow++;
    end
    rend = prow >= h;
    last = rend && (!hx || tile_last());
    emit_cmd(CMD_PIXEL, px, py, 1, 1, gather, 0, 0, last);
    if (rend) begin
      prow = 0;
      if (hx) tile_next();
      else phase = P_IDLE;
    end
  endfunction

  // one stream byte through the mirrored decoder
  function void decode_byte(logic [7:0] b, logic hdr);
    int n;
    bit rre, col, last;
    int sx, sy, sw, sh;
    emitted = 0;
    if (hdr) begin
      phase = P_HDR;
      bidx = 0;
    end
    case (phase)
      P_HDR: begin
        if (bidx < 8) geom = {geom[55:0], b};
        else gather = {gather[23:0], b};
        if (bidx < 11) bidx++;
        else header_done();
      end
      P_PIX: pixel_in(b);
      P_COPY: begin
        gather = {gather[23:0], b};
        if (bidx < 3) bidx++;
        else begin
          phase = P_IDLE;
          bidx = 0;
          emit_cmd(CMD_COPY, rl, rt, rw, rh, 0, gather[31:16] - crop_x,
                   gather[15:0] - crop_y, 1);
        end
      end
      P_RHEAD: begin
        if (bidx < 4) subs_left = {subs_left[23:0], b};
        else gather = {b, gather[31:8]};
        if (bidx < 4 + PIXEL_BYTES - 1) bidx++;
        else begin
          bidx = 0;
          bg_col = gather;
          phase = subs_left == 0 ? P_IDLE : P_RSUB;
          emit_cmd(CMD_FILL, rl, rt, rw, rh, bg_col, 0, 0, subs_left == 0);
        end
      end
      P_RSUB: begin
        rre = enc_type == ENC_RRE;
        n = rre ? PIXEL_BYTES + 8 : PIXEL_BYTES + 4;
        if (bidx < PIXEL_BYTES) gather = {b, gather[31:8]};
        else geom = {geom[55:0], b};
        if (bidx < n - 1) bidx++;
        else begin
          bidx = 0;
          if (rre) begin
            sx = geom[63:48]; sy = geom[47:32]; sw = geom[31:16]; sh = geom[15:0];
          end else begin
            sx = geom[31:24]; sy = geom[23:16]; sw = geom[15:8]; sh = geom[7:0];
          end
          subs_left--;
          if (subs_left == 0) phase = P_IDLE;
          emit_cmd(CMD_FILL, rl + sx, rt + sy, sw, sh, gather, 0, 0, subs_left == 0);
        end
      end
      P_XENC: begin
        tflags = b[4:0];
        bidx = 0;
        if (tflags[0]) begin
          pcol = 0;
          prow = 0;
          phase = P_PIX;
        end else prefix_next(0);
      end
      P_XBG, P_XFG: begin
        gather = {b, gather[31:8]};
        if (bidx < PIXEL_BYTES - 1) bidx++;
        else if (phase == P_XBG) begin
          bg_col = gather;
          prefix_next(1);
        end else begin
          fg_col = gather;
          prefix_next(2);
        end
      end
      P_XCOUNT: begin
        subs_left = b;
        bidx = 0;
        if (b != 0) phase = P_XSUB;
        tile_fill(b != 0);
      end
      P_XSUB: begin
        col = tflags[4];
        n = col ? PIXEL_BYTES + 2 : 2;
        if (bidx < n - 2) gather = {b, gather[31:8]};
        else geom = {geom[55:0], b};
        if (bidx < n - 1) bidx++;
        else begin
          bidx = 0;
          if (col) fg_col = gather;
          subs_left--;
          last = subs_left == 0 && tile_last();
          emit_cmd(CMD_FILL, tl + geom[15:12], tt + geom[11:8], 1 + geom[7:4],
                   1 + geom[3:0], fg_col, 0, 0, last);
          if (subs_left == 0) tile_next();
        end
      end
      default: ;
    endcase
  endfunction

  // ---- stimulus generation ----
  function void add_bytes(int n);
    for (int i = 0; i < n && payload.size() < cap; i++) payload.push_back($urandom);
  endfunction

  function void queue_rect(logic [15:0] x, logic [15:0] y, logic [15:0] w,
                           logic [15:0] h, logic [31:0] enc, int cut, int noise);
    logic [95:0] hd;
    logic [31:0] cnt;
    logic [4:0]  fl;
    int c, tw, th;
    hd = {x, y, w, h, enc};
    payload.delete();
    cap = cut >= 0 ? cut : 4000;
    for (int i = 0; i < 12; i++) pend.push_back({i == 0, hd[95 - 8*i -: 8]});
    case (enc)
      ENC_RAW: add_bytes(int'(w) * int'(h) * PIXEL_BYTES);
      ENC_COPY: add_bytes(4);
      ENC_RRE, ENC_CORE: begin
        cnt = $urandom_range(0, 3);
        if ($urandom_range(9) == 0) begin
          cnt = $urandom;
          cap = $urandom_range(0, 60);
        end
        for (int i = 0; i < 4; i++) payload.push_back(cnt[31 - 8*i -: 8]);
        add_bytes(PIXEL_BYTES);
        for (longint i = 0; i < cnt && payload.size() < cap; i++)
          add_bytes(enc == ENC_RRE ? 12 : 8);
      end
      ENC_HEX: begin
        for (int ty = 0; ty < h && payload.size() < cap; ty += TILE_SIZE)
          for (int tx = 0; tx < w && payload.size() < cap; tx += TILE_SIZE) begin
            tw = w - tx > TILE_SIZE ? TILE_SIZE : w - tx;
            th = h - ty > TILE_SIZE ? TILE_SIZE : h - ty;
            fl = $urandom;
            // raw tiles only where small, to keep the byte count down
            if (tw * th > 16) fl[0] = 1'b0;
            payload.push_back({3'($urandom_range(0, 7)), fl});
            if (fl[0]) add_bytes(tw * th * PIXEL_BYTES);
            else begin
              if (fl[1]) add_bytes(PIXEL_BYTES);
              if (fl[2]) add_bytes(PIXEL_BYTES);
              if (fl[3]) begin
                c = $urandom_range(0, 4);
                payload.push_back(c);
                for (int s = 0; s < c; s++) add_bytes(fl[4] ? PIXEL_BYTES + 2 : 2);
              end
            end
          end
      end
      default: ;
    endcase
    while (payload.size() > cap) void'(payload.pop_back());
    foreach (payload[i]) pend.push_back({1'b0, payload[i]});
    for (int i = 0; i < noise; i++) pend.push_back({1'b0, 8'($urandom)});
  endfunction

  function rect_row_t mk_row(int x, int y, int w, int h, logic [31:0] enc,
                             int cut, int noise);
    rect_row_t r;
    r.x = x; r.y = y; r.w = w; r.h = h; r.enc = enc;
    r.cut = cut; r.noise = noise; r.typed = 0; r.want = '0;
    return r;
  endfunction

  // ---- channel and register drivers ----
  task automatic push_byte(logic [7:0] b, logic hdr);
    bit st;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 0;
      stream_byte = $urandom;
      header_start = $urandom;
      @(negedge clk);
    end
    in_valid = 1;
    stream_byte = b;
    header_start = hdr;
    forever begin
      #1 st = in_stall;
      @(posedge clk);
      if (!st) break;
      @(negedge clk);
    end
    nbytes++;
    decode_byte(b, hdr);
    if (emitted) begin
      cmd_expq.push_back(typed_on ? typed_cmd : cmd_out);
      typed_on = 0;
    end
  endtask

  task automatic send_pending();
    logic [8:0] e;
    while (pend.size() > 0) begin
      e = pend.pop_front();
      push_byte(e[7:0], e[8]);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk) in_valid = 0;
    while (cmd_expq.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [15:0] v);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = {16'd0, v};
    @(negedge clk) penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    case (idx)
      REG_CROP_X:  crop_x  = v;
      REG_CROP_Y:  crop_y  = v;
      REG_FRAME_W: frame_w = v;
      REG_FRAME_H: frame_h = v;
    endcase
  endtask

  // settle the block, then load all four registers
  task automatic set_config(logic [15:0] cx, logic [15:0] cy, logic [15:0] fw,
                            logic [15:0] fh);
    wait_drained();
    repeat (10) @(posedge clk);
    reg_write(REG_CROP_X, cx);
    reg_write(REG_CROP_Y, cy);
    reg_write(REG_FRAME_W, fw);
    reg_write(REG_FRAME_H, fh);
  endtask

  task automatic rand_rect();
    int e, lim, cut, noise;
    logic [31:0] enc;
    logic [15:0] x, y, w, h;
    e = $urandom_range(99);
    if (e < 20) enc = ENC_RAW;
    else if (e < 30) enc = ENC_COPY;
    else if (e < 45) enc = ENC_RRE;
    else if (e < 60) enc = ENC_CORE;
    else if (e < 90) enc = ENC_HEX;
    else begin
      enc = $urandom_range(0, 1) ? 32'($urandom) : 32'd3;
      if (enc inside {ENC_RAW, ENC_COPY, ENC_RRE, ENC_CORE, ENC_HEX}) enc = 32'd3;
    end
    lim = enc == ENC_HEX ? 20 : 6;
    w = $urandom_range(0, lim);
    h = $urandom_range(0, lim);
    x = $urandom_range(0, 1) ? 16'($urandom) : 16'(crop_x + $urandom_range(0, 50));
    y = $urandom_range(0, 1) ? 16'($urandom) : 16'(crop_y + $urandom_range(0, 50));
    cut = -1;
    if ($urandom_range(24) == 0) begin
      w = $urandom;
      h = $urandom;
      cut = $urandom_range(0, 40);
    end else if ($urandom_range(11) == 0) cut = $urandom_range(0, 20);
    noise = $urandom_range(11) == 0 ? $urandom_range(1, 3) : 0;
    queue_rect(x, y, w, h, enc, cut, noise);
    send_pending();
  endtask

  task automatic mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errs++;
  endtask

  // ---- result checking ----
  initial begin
    cmd_t g, e;
    bit v;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall = 1;
        hold--;
      end else out_stall = $urandom_range(99) < stall_pct;
      #1;
      v = out_valid;
      g = mk_cmd(command_kind, int'(dest_x), int'(dest_y), fill_width, fill_height,
                 pixel_color, copy_src_x, copy_src_y, rect_done);
      @(posedge clk);
      if (v && !out_stall) begin
        if (cmd_expq.size() == 0) mismatch("unexpected command", g.kind, 0);
        else begin
          e = cmd_expq.pop_front();
          if (g.kind != e.kind) mismatch("command_kind", g.kind, e.kind);
          if (g.dx != e.dx) mismatch("dest_x", g.dx, e.dx);
          if (g.dy != e.dy) mismatch("dest_y", g.dy, e.dy);
          if (g.w != e.w) mismatch("fill_width", g.w, e.w);
          if (g.h != e.h) mismatch("fill_height", g.h, e.h);
          if (g.color != e.color) mismatch("pixel_color", g.color, e.color);
          if (g.sx != e.sx) mismatch("copy_src_x", g.sx, e.sx);
          if (g.sy != e.sy) mismatch("copy_src_y", g.sy, e.sy);
          if (g.done != e.done) mismatch("rect_done", g.done, e.done);
        end
      end
    end
  end

  // run limit
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  // ---- main sequence ----
  initial begin
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; stream_byte = 0; header_start = 0;
    errs = 0; nbytes = 0; gap_pct = 0; stall_pct = 0; hold = 0; typed_on = 0;
    crop_x = 0; crop_y = 0; frame_w = 0; frame_h = 0;
    phase = P_IDLE; bidx = 0; gather = 0; enc_type = 0; subs_left = 0;
    bg_col = 0; fg_col = 0; rl = 0; rt = 0; rw = 0; rh = 0; tl = 0; tt = 0;
    pcol = 0; prow = 0; tflags = 0; geom = 0;

    // directed rectangles; typed expectations where obvious
    dir_tab[0]  = mk_row(0, 0, 1, 1, ENC_RAW, -1, 0);
    dir_tab[0].typed = 1;
    dir_tab[0].want  = mk_cmd(CMD_SIZEERR, 0, 0, 1, 1, 0, 0, 0, 1);
    dir_tab[1]  = mk_row(5, 6, 2, 3, 32'd7, -1, 2);
    dir_tab[1].typed = 1;
    dir_tab[1].want  = mk_cmd(CMD_UNKNOWN, 5, 6, 2, 3, 0, 0, 0, 1);
    dir_tab[2]  = mk_row(0, 0, 0, 0, 32'hFFFF_FFFF, -1, 0);
    dir_tab[2].typed = 1;
    dir_tab[2].want  = mk_cmd(CMD_UNKNOWN, 0, 0, 0, 0, 0, 0, 0, 1);
    dir_tab[3]  = mk_row(1, 2, 0, 3, ENC_RAW, -1, 0);
    dir_tab[3].typed = 1;
    dir_tab[3].want  = mk_cmd(CMD_FILL, 1, 2, 0, 3, 0, 0, 0, 1);
    dir_tab[4]  = mk_row(0, 0, 4, 0, ENC_HEX, -1, 0);
    dir_tab[4].typed = 1;
    dir_tab[4].want  = mk_cmd(CMD_FILL, 0, 0, 4, 0, 0, 0, 0, 1);
    dir_tab[5]  = mk_row(3, 4, 2, 2, ENC_RAW, -1, 0);
    dir_tab[6]  = mk_row(100, 200, 30, 40, ENC_COPY, -1, 0);
    dir_tab[7]  = mk_row(10, 20, 50, 60, ENC_RRE, -1, 0);
    dir_tab[8]  = mk_row(7, 9, 40, 30, ENC_CORE, -1, 0);
    dir_tab[9]  = mk_row(2, 2, 1, 1, ENC_HEX, -1, 0);
    dir_tab[10] = mk_row(0, 0, 17, 18, ENC_HEX, -1, 0);
    dir_tab[11] = mk_row(65535, 65535, 1, 1, ENC_RAW, -1, 0);
    dir_tab[12] = mk_row(40, 1, 33, 5, ENC_HEX, -1, 0);
    dir_tab[13] = mk_row(65535, 65535, 0, 0, ENC_COPY, -1, 0);
    // truncated payload, so the next header arrives mid-rectangle
    dir_tab[14] = mk_row(8, 8, 4, 4, ENC_RAW, 10, 0);

    repeat (8) @(posedge clk);
    @(negedge clk) rst = 0;

    // frame size still zero after reset
    foreach (dir_tab[i]) begin
      if (i == 1) set_config(0, 0, 16'hFFFF, 16'hFFFF);
      queue_rect(dir_tab[i].x, dir_tab[i].y, dir_tab[i].w, dir_tab[i].h,
                 dir_tab[i].enc, dir_tab[i].cut, dir_tab[i].noise);
      typed_on = dir_tab[i].typed;
      typed_cmd = dir_tab[i].want;
      send_pending();
    end

    // random phases over several register settings and idling patterns
    for (int p = 0; p < 4; p++) begin
      int target, mid;
      bit paused;
      case (p)
        0: begin set_config(0, 0, 16'hFFFF, 16'hFFFF); gap_pct = 0; stall_pct = 0; end
        1: begin
          set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          gap_pct = 59; stall_pct = 0;
        end
        2: begin
          set_config($urandom_range(0, 40), $urandom_range(0, 40), $urandom, $urandom);
          gap_pct = 0; stall_pct = 59;
        end
        default: begin
          set_config($urandom, $urandom, $urandom_range(0, 300), $urandom_range(0, 300));
          gap_pct = 23; stall_pct = 23;
        end
      endcase
      target = nbytes + 100;
      mid = nbytes + 50;
      paused = 0;
      while (nbytes < target) begin
        if (!paused && nbytes >= mid) begin
          paused = 1;
          if (p == 1) wait_drained();
          if (p == 2) hold = 400;
        end
        rand_rect();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errs == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[remote_framebuffer_rect_decoder.f]
src/rfb_pkg.sv
src/rfb_queue.sv
src/rfb_parser.sv
src/remote_framebuffer_rect_decoder.sv
tb/remote_framebuffer_rect_decoder_test.sv
